/* rtl/core/bcw_pkg.sv */
// Package for the packet CRC-24 / whitening encoder.
// Holds constants, shared types and the bit-level LFSR functions.
// No dependencies.
`timescale 1ns / 1ps

package bcw_pkg;

    localparam int unsigned CrcWidth   = 24;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned BurstLen   = 4;
    localparam int unsigned CountWidth = 3;

    localparam logic [CrcWidth-1:0]  CRC_POLY   = 24'h00065B;
    localparam logic [CrcWidth-1:0]  CRC_RESET  = 24'h555555;
    localparam logic [ByteWidth-1:0] WHITEN_TAP = 8'h11;
    localparam logic [ByteWidth-1:0] WHITEN_MSB = 8'h80;

    // One input request as held in the input register.
    typedef struct packed {
        logic [ByteWidth-1:0] data_byte;
        logic                 first_byte;
        logic                 last_byte;
        logic [ByteWidth-1:0] whiten_seed;
    } item_t;

    // Everything one request produces, plus the running state after it.
    typedef struct packed {
        logic [BurstLen-1:0][ByteWidth-1:0] bytes;
        logic                               burst;
        logic [CrcWidth-1:0]                crc_next;
        logic [ByteWidth-1:0]               wh_next;
    } enc_result_t;

    function automatic logic [ByteWidth-1:0] reverse8(input logic [ByteWidth-1:0] b);
        logic [ByteWidth-1:0] r;
        for (int i = 0; i < ByteWidth; i++)
        begin
            r[i] = b[ByteWidth-1-i];
        end
        return r;
    endfunction

    // Eight CRC steps, data LSB first.
    function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc_in,
                                                      input logic [ByteWidth-1:0] d);
        logic [CrcWidth-1:0] c;
        logic                top;
        c = crc_in;
        for (int i = 0; i < ByteWidth; i++)
        begin
            top = c[CrcWidth-1];
            c   = {c[CrcWidth-2:0], 1'b0};
            if (top != d[i])
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Whitens one byte, LSB first; returns {register after, whitened byte}.
    function automatic logic [2*ByteWidth-1:0] whiten_byte(input logic [ByteWidth-1:0] wh_in,
                                                           input logic [ByteWidth-1:0] d);
        logic [ByteWidth-1:0] w;
        logic [ByteWidth-1:0] b;
        w = wh_in;
        b = d;
        for (int i = 0; i < ByteWidth; i++)
        begin
            if ((w & WHITEN_MSB) != '0)
            begin
                w    = w ^ WHITEN_TAP;
                b[i] = ~b[i];
            end
            w = {w[ByteWidth-2:0], 1'b0};
        end
        return {w, b};
    endfunction

endpackage

/* rtl/core/bcw_encode.sv */
// Combinational encoder: CRC update and whitening of one request, plus the
// three trailing CRC bytes when the request closes a packet. Uses bcw_pkg.
`timescale 1ns / 1ps

module bcw_encode
    import bcw_pkg::*;
(
    input  item_t                item,
    input  logic [CrcWidth-1:0]  crc_cur,
    input  logic [ByteWidth-1:0] wh_cur,
    input  logic [CrcWidth-1:0]  crc_preset,
    output enc_result_t          result
);

    logic [CrcWidth-1:0]    crc_start;
    logic [ByteWidth-1:0]   wh_start;
    logic [CrcWidth-1:0]    crc_after;
    logic [2*ByteWidth-1:0] w_data;
    logic [2*ByteWidth-1:0] w_crc0;
    logic [2*ByteWidth-1:0] w_crc1;
    logic [2*ByteWidth-1:0] w_crc2;

    always_comb
    begin
        crc_start = item.first_byte ? crc_preset : crc_cur;
        wh_start  = item.first_byte ? item.whiten_seed : wh_cur;
        crc_after = crc_byte(crc_start, item.data_byte);

        w_data = whiten_byte(wh_start, item.data_byte);
        // CRC bytes go out MSB byte first, whitening register keeps running
        w_crc0 = whiten_byte(w_data[2*ByteWidth-1:ByteWidth], reverse8(crc_after[23:16]));
        w_crc1 = whiten_byte(w_crc0[2*ByteWidth-1:ByteWidth], reverse8(crc_after[15:8]));
        w_crc2 = whiten_byte(w_crc1[2*ByteWidth-1:ByteWidth], reverse8(crc_after[7:0]));

        result.bytes[0] = reverse8(w_data[ByteWidth-1:0]);
        result.bytes[1] = reverse8(w_crc0[ByteWidth-1:0]);
        result.bytes[2] = reverse8(w_crc1[ByteWidth-1:0]);
        result.bytes[3] = reverse8(w_crc2[ByteWidth-1:0]);
        result.burst    = item.last_byte;
        result.crc_next = crc_after;
        result.wh_next  = item.last_byte ? w_crc2[2*ByteWidth-1:ByteWidth]
                                         : w_data[2*ByteWidth-1:ByteWidth];
    end

endmodule

/* rtl/core/bcw_obuf.sv */
// Output buffer: holds one result byte, or a four-byte burst (data byte
// plus CRC bytes), and drains it one byte per transfer. Uses bcw_pkg.
`timescale 1ns / 1ps

module bcw_obuf
    import bcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  enc_result_t          result,
    output logic                 can_load,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ByteWidth-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic                 m_axis_tlast    // end_of_packet
);

    logic [CountWidth-1:0]              cnt_reg;
    logic [CountWidth-1:0]              cnt_next;
    logic [BurstLen-1:0][ByteWidth-1:0] byte_reg;
    logic [BurstLen-1:0][ByteWidth-1:0] byte_next;
    logic [BurstLen-1:0]                eop_reg;
    logic [BurstLen-1:0]                eop_next;
    logic                               take;

    assign take          = (cnt_reg != '0) && m_axis_tready;
    assign can_load      = (cnt_reg == '0) || ((cnt_reg == CountWidth'(1)) && m_axis_tready);
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = byte_reg[0];
    assign m_axis_tlast  = eop_reg[0];

    always_comb
    begin
        cnt_next  = cnt_reg;
        byte_next = byte_reg;
        eop_next  = eop_reg;
        if (load)
        begin
            byte_next = result.bytes;
            eop_next  = {result.burst, {(BurstLen-1){1'b0}}};
            cnt_next  = result.burst ? CountWidth'(BurstLen) : CountWidth'(1);
        end
        else if (take)
        begin
            for (int i = 0; i < BurstLen - 1; i++)
            begin
                byte_next[i] = byte_reg[i+1];
                eop_next[i]  = eop_reg[i+1];
            end
            byte_next[BurstLen-1] = byte_reg[BurstLen-1];
            eop_next[BurstLen-1]  = 1'b0;
            cnt_next = cnt_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eop_reg  <= eop_next;
    end

endmodule

/* rtl/core/ble_packet_crc_whiten_encoder_unit.sv */
// Top level of the packet CRC-24 / whitening encoder.
// Instantiates bcw_encode and bcw_obuf; uses bcw_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one packet byte per request: tdata[7:0] data byte,
//   tdata[15:8] whitening seed, tuser marks the first byte (loads the CRC
//   preset and the seed), tlast marks the last data byte.
//   m_axis gives one encoded byte per request; a request with tlast set
//   produces four output bytes (the data byte then three CRC bytes), and
//   m_axis_tlast is high on the last CRC byte.
//   cfg_valid/cfg_data write the 24-bit CRC preset; cfg_ready is always
//   high. A new preset takes effect at the next first byte.
// Timing:
//   An accepted byte is captured in the input register, encoded by
//   combinational logic and loaded into the output buffer, which drives m_axis.
//   Throughput is one byte per cycle while m_axis_tready stays high; a
//   closing byte occupies the output buffer for all four of its bytes,
//   during which input stalls once the input register is full.
// Reset: rst_n clears the buffers, sets the CRC register and preset to
//   0x555555 and the whitening register to zero.
// Stall: when m_axis_tready is low the output buffer and then the input
//   register hold, and s_axis_tready falls.
module ble_packet_crc_whiten_encoder_unit
    import bcw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*ByteWidth-1:0] s_axis_tdata,   // [7:0] data_byte, [15:8] whiten_seed
    input  logic                   s_axis_tuser,   // first_byte
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [ByteWidth-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tlast,   // end_of_packet
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CrcWidth-1:0]    cfg_data
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    item_t                item_reg;
    logic [CrcWidth-1:0]  crc_reg;
    logic [CrcWidth-1:0]  crc_next;
    logic [ByteWidth-1:0] wh_reg;
    logic [ByteWidth-1:0] wh_next;
    logic [CrcWidth-1:0]  preset_reg;
    logic [CrcWidth-1:0]  preset_next;
    enc_result_t          result;
    logic                 can_load;
    logic                 advance;
    logic                 s_take;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    bcw_encode u_encode (
        .item       (item_reg),
        .crc_cur    (crc_reg),
        .wh_cur     (wh_reg),
        .crc_preset (preset_reg),
        .result     (result)
    );

    bcw_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        crc_next    = advance ? result.crc_next : crc_reg;
        wh_next     = advance ? result.wh_next : wh_reg;
        preset_next = cfg_valid ? cfg_data : preset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            crc_reg      <= CRC_RESET;
            wh_reg       <= '0;
            preset_reg   <= CRC_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            crc_reg      <= crc_next;
            wh_reg       <= wh_next;
            preset_reg   <= preset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            item_reg.data_byte   <= s_axis_tdata[ByteWidth-1:0];
            item_reg.whiten_seed <= s_axis_tdata[2*ByteWidth-1:ByteWidth];
            item_reg.first_byte  <= s_axis_tuser;
            item_reg.last_byte   <= s_axis_tlast;
        end
    end

endmodule

/* test/testbench.sv */
// Self-checking bench for ble_packet_crc_whiten_encoder_unit: CRC-24 and whitening of packet bytes.
// A class tracks CRC/whitening state and queues the expected air bytes; tasks drive the streams.
// Depends on bcw_pkg and the encoder RTL.
`timescale 1ns / 1ps

module testbench
    import bcw_pkg::*;
();

    localparam logic [23:0] CRC24_TAPS    = 24'h00065B;
    localparam logic [23:0] CRC24_DEFAULT = 24'h555555;
    localparam logic [7:0]  WHITEN_FB     = 8'h11;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
    } air_byte_t;

    // Running CRC/whitening state and the queue of bytes the encoder still owes.
    class air_byte_tracker;
        logic [23:0] preset;
        logic [23:0] crc_reg;
        logic [7:0]  wh_reg;
        air_byte_t   owed_bytes[$];
        int unsigned requests;
        int unsigned packets_closed;
        int unsigned bytes_checked;
        int unsigned mismatches;

        function new();
            preset         = CRC24_DEFAULT;
            crc_reg        = CRC24_DEFAULT;
            wh_reg         = 8'h00;
            requests       = 0;
            packets_closed = 0;
            bytes_checked  = 0;
            mismatches     = 0;
        endfunction

        function void load_preset(input logic [23:0] v);
            preset = v;
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction

        function logic [7:0] flip(input logic [7:0] b);
            logic [7:0] r;
            for (int i = 0; i < 8; i++)
            begin
                r[7-i] = b[i];
            end
            return r;
        endfunction

        function void crc_absorb(input logic [7:0] d);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb      = crc_reg[23] ^ d[i];
                crc_reg = {crc_reg[22:0], 1'b0};
                if (fb)
                begin
                    crc_reg = crc_reg ^ CRC24_TAPS;
                end
            end
        endfunction

        function logic [7:0] whiten(input logic [7:0] d);
            logic [7:0] b;
            b = d;
            for (int i = 0; i < 8; i++)
            begin
                if (wh_reg[7])
                begin
                    wh_reg = wh_reg ^ WHITEN_FB;
                    b[i]   = ~b[i];
                end
                wh_reg = {wh_reg[6:0], 1'b0};
            end
            return b;
        endfunction

        // One accepted request: the data byte, plus the three CRC bytes on a closing byte.
        function void absorb_request(input logic [7:0] d, input logic first,
                                     input logic last, input logic [7:0] seed);
            air_byte_t   ab;
            logic [23:0] crc_snap;
            requests++;
            if (first)
            begin
                crc_reg = preset;
                wh_reg  = seed;
            end
            crc_absorb(d);
            ab.out_byte      = flip(whiten(d));
            ab.end_of_packet = 1'b0;
            owed_bytes.push_back(ab);
            if (last)
            begin
                packets_closed++;
                crc_snap = crc_reg;
                for (int k = 0; k < 3; k++)
                begin
                    ab.out_byte      = flip(whiten(flip(crc_snap[23-8*k -: 8])));
                    ab.end_of_packet = (k == 2);
                    owed_bytes.push_back(ab);
                end
            end
        endfunction

        function void compare_air_byte(input logic [7:0] got_byte, input logic got_eop);
            air_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                $error("unexpected output byte %02h (tlast %0b) with nothing owed",
                       got_byte, got_eop);
                mismatches++;
                return;
            end
            want = owed_bytes.pop_front();
            bytes_checked++;
            if (got_byte !== want.out_byte)
            begin
                $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, got_byte);
                mismatches++;
            end
            if (got_eop !== want.end_of_packet)
            begin
                $error("end_of_packet mismatch: expected %0b, got %0b",
                       want.end_of_packet, got_eop);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [2*ByteWidth-1:0] s_axis_tdata = '0;     // [7:0] data_byte, [15:8] whiten_seed
    logic                   s_axis_tuser = 1'b0;   // first_byte
    logic                   s_axis_tlast = 1'b0;   // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [ByteWidth-1:0]   m_axis_tdata;          // [7:0] out_byte
    logic                   m_axis_tlast;          // end_of_packet
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CrcWidth-1:0]    cfg_data = '0;

    air_byte_tracker tracker = new();
    int unsigned     burst_left = 0;
    int unsigned     presets_used = 0;

    logic [1:0]      stall_style = 2'd0;
    int unsigned     ready_span = 0;
    logic [15:0]     ready_pattern = 16'hFFFF;

    always #2 clk = ~clk;

    ble_packet_crc_whiten_encoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Handshake monitor: preset writes, accepted requests, delivered bytes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                tracker.load_preset(cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.absorb_request(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast,
                                       s_axis_tdata[15:8]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.compare_air_byte(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // Receiver back-pressure: always ready, coin flips, a rotating pattern, or blocks set by bit 3 of the span counter.
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            stall_style   <= 2'($urandom_range(0, 3));
            ready_span    <= $urandom_range(16, 96);
            ready_pattern <= 16'($urandom) | 16'h0001;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            ready_span <= ready_span - 1;
            case (stall_style)
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:
                begin
                    m_axis_tready <= ready_pattern[0];
                    ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                end
                default: m_axis_tready <= ready_span[3];
            endcase
        end
    end

    task automatic put_byte(input logic [7:0] d, input logic first, input logic last,
                            input logic [7:0] seed);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {seed, d};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Stop sending and let every owed byte come out before touching the preset.
    task automatic drain_encoder();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_preset(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        presets_used++;
    endtask

    initial
    begin
        int unsigned count;
        int unsigned len;
        logic [23:0] phase_preset [4];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start mark yet: zero whitening register, CRC running from reset value.
        put_byte(8'h3C, 1'b0, 1'b0, 8'hE7);
        put_byte(8'hFF, 1'b0, 1'b1, 8'hFF);
        // One-byte packet, zero seed.
        put_byte(8'h00, 1'b1, 1'b1, 8'h00);
        put_byte(8'hFF, 1'b1, 1'b0, 8'hFF);
        put_byte(8'h80, 1'b0, 1'b0, 8'h00);
        put_byte(8'h01, 1'b0, 1'b1, 8'h5A);
        // Bytes after a packet end carry on from the old registers.
        put_byte(8'hA5, 1'b0, 1'b0, 8'h3C);
        put_byte(8'h5A, 1'b0, 1'b1, 8'hC3);
        drain_encoder();
        write_preset(24'h000000);
        // New preset not in force until the next start byte.
        put_byte(8'h11, 1'b0, 1'b0, 8'h81);
        put_byte(8'hC3, 1'b1, 1'b0, 8'h80);
        put_byte(8'h7E, 1'b0, 1'b1, 8'h01);
        drain_encoder();
        write_preset(24'hFFFFFF);
        put_byte(8'hFF, 1'b1, 1'b1, 8'h01);
        put_byte(8'h00, 1'b1, 1'b0, 8'h7F);
        put_byte(8'hFF, 1'b0, 1'b0, 8'h00);
        put_byte(8'h00, 1'b0, 1'b1, 8'hFF);

        phase_preset[0] = 24'($urandom);
        phase_preset[1] = 24'h000000;
        phase_preset[2] = 24'hFFFFFF;
        phase_preset[3] = CRC24_DEFAULT;
        for (int p = 0; p < 4; p++)
        begin
            drain_encoder();
            write_preset(phase_preset[p]);
            count = 0;
            while (count < 30)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray byte with arbitrary marks
                    put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    count++;
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16)
                                                      : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                    begin
                        put_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1,
                                 8'($urandom_range(0, 255)));
                    end
                    count += len;
                end
            end
        end

        drain_encoder();
        $display("Covered %0d requests in %0d closed packets, %0d encoded bytes checked,",
                 tracker.requests, tracker.packets_closed, tracker.bytes_checked);
        $display("under %0d CRC preset settings with random source gaps and sink stalls.",
                 presets_used);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("ble_packet_crc_whiten_encoder_unit verification clean");
        end
        else
        begin
            $display("ble_packet_crc_whiten_encoder_unit verification failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("ble_packet_crc_whiten_encoder_unit verification failed");
        $finish;
    end

endmodule

/* ble_packet_crc_whiten_encoder_unit.f */
rtl/core/bcw_pkg.sv
rtl/core/bcw_encode.sv
rtl/core/bcw_obuf.sv
rtl/core/ble_packet_crc_whiten_encoder_unit.sv
test/testbench.sv
